// ----- src/ppm_p6_stream_decoder_unit_assert.svh -----
// Assertion macros for the PPM P6 stream decoder checker.
// Included by the checker module; depends on nothing else.
`ifndef PPM_P6_STREAM_DECODER_UNIT_ASSERT_SVH
`define PPM_P6_STREAM_DECODER_UNIT_ASSERT_SVH

// Overlapping implication, quiet while reset is asserted.
`define PPM_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, active during reset too.
`define PPM_ASSERT_NEXT(label, clk, cond, prop, msg) \
    label: assert property (@(posedge clk) (cond) |=> (prop)) else $error(msg);

`endif

// ----- src/ppm_pkg.sv -----
// Shared types and constants of the PPM P6 stream decoder.
// Used by ppm_front, ppm_back, the top level and the checker; depends on nothing.
package ppm_pkg;

    localparam int DIM_W = 13;
    localparam int PIX_W = 32;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] ALPHA    = 8'hFF;
    localparam int         MAXVAL   = 255;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        PH_MAGIC0 = 4'd0,
        PH_MAGIC1 = 4'd1,
        PH_SKIP_W = 4'd2,
        PH_NUM_W  = 4'd3,
        PH_SKIP_H = 4'd4,
        PH_NUM_H  = 4'd5,
        PH_SKIP_M = 4'd6,
        PH_NUM_M  = 4'd7,
        PH_PIXELS = 4'd8,
        PH_DONE   = 4'd9
    } t_phase;

    typedef struct packed {
        logic       eos;
        logic [7:0] data;
        logic       is_digit;
        logic       is_space;
        logic       is_hash;
        logic       is_nl;
        logic       is_sign;
        logic       is_minus;
        logic       is_p;
        logic       is_six;
    } t_cls;

    typedef struct packed {
        t_kind              kind;
        logic [PIX_W-1:0]   pixel;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic               last_pixel;
    } t_res;

endpackage

// ----- src/ppm_fifo.sv -----
// Small register queue used between the stages of the PPM P6 decoder.
// Generic in width and depth; depends on nothing.
module ppm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- src/ppm_front.sv -----
// Byte classifier of the PPM P6 decoder front end.
// Depends on ppm_pkg for the character constants and the class record.
module ppm_front
    import ppm_pkg::*;
(
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_stream,
    output t_cls       o_cls
);
    always_comb begin
        o_cls.eos      = i_end_of_stream;
        o_cls.data     = i_data_byte;
        o_cls.is_digit = (i_data_byte >= CH_ZERO) && (i_data_byte <= CH_NINE);
        o_cls.is_space = (i_data_byte == CH_SPACE) ||
                         ((i_data_byte >= CH_TAB) && (i_data_byte <= CH_CR));
        o_cls.is_hash  = (i_data_byte == CH_HASH);
        o_cls.is_nl    = (i_data_byte == CH_NL);
        o_cls.is_sign  = (i_data_byte == CH_PLUS) || (i_data_byte == CH_MINUS);
        o_cls.is_minus = (i_data_byte == CH_MINUS);
        o_cls.is_p     = (i_data_byte == CH_P);
        o_cls.is_six   = (i_data_byte == CH_SIX);
    end

endmodule

// ----- src/ppm_back.sv -----
// Header parser and pixel packer of the PPM P6 decoder back end.
// Depends on ppm_pkg for the phase, class and result types.
module ppm_back
    import ppm_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_cls i_cls,
    output logic o_take,
    input  logic i_res_full,
    output logic o_res_push,
    output t_res o_res
);
    localparam int NUM_CAP = ((MAX_DIM > MAXVAL) ? MAX_DIM : MAXVAL) + 1;
    localparam int AW      = $clog2(NUM_CAP + 1);
    localparam int PW      = $clog2(MAX_DIM * MAX_DIM + 1);

    t_phase          r_phase, n_phase;
    logic [AW-1:0]   r_acc, n_acc;
    logic            r_neg, n_neg;
    logic            r_digit_seen, n_digit_seen;
    logic            r_in_comment, n_in_comment;
    logic [AW-1:0]   r_width, n_width;
    logic [AW-1:0]   r_height, n_height;
    logic [1:0]      r_ch, n_ch;
    logic [7:0]      r_red, n_red;
    logic [7:0]      r_green, n_green;
    logic [PW-1:0]   r_left, n_left;

    logic            w_go, w_eos;
    logic            w_phase_skip, w_num, w_term, w_reparse, w_skip_mode, w_cmt;
    logic            w_skip_take, w_skip_bad, w_hdr_bad, w_fail, w_header, w_pix;
    logic            w_last;
    t_phase          w_skip_stay, w_skip_next;
    logic [AW-1:0]   w_dim;
    logic [AW+3:0]   w_acc_next;
    logic [2*AW-1:0] w_prod;

    assign w_go   = i_valid && !i_res_full;
    assign o_take = w_go;
    assign w_eos  = i_cls.eos;

    always_comb begin
        w_phase_skip = (r_phase == PH_SKIP_W) || (r_phase == PH_SKIP_H) ||
                       (r_phase == PH_SKIP_M);
        w_num        = (r_phase == PH_NUM_W) || (r_phase == PH_NUM_H) ||
                       (r_phase == PH_NUM_M);
        w_term       = !w_eos && w_num && !i_cls.is_digit;
        w_reparse    = w_term && r_digit_seen && (r_phase != PH_NUM_M);
        w_skip_mode  = (!w_eos && w_phase_skip) || w_reparse;
        w_cmt        = w_phase_skip && r_in_comment;
        w_skip_take  = w_skip_mode && !w_cmt && !i_cls.is_hash && !i_cls.is_space &&
                       (i_cls.is_sign || i_cls.is_digit);
        w_skip_bad   = w_skip_mode && !w_cmt && !i_cls.is_hash && !i_cls.is_space &&
                       !i_cls.is_sign && !i_cls.is_digit;
        w_hdr_bad    = (r_width == '0) || (r_width > AW'(MAX_DIM)) ||
                       (r_height == '0) || (r_height > AW'(MAX_DIM)) ||
                       r_neg || (r_acc != AW'(MAXVAL));
        w_fail       = !w_eos && (
                       ((r_phase == PH_MAGIC0) && !i_cls.is_p) ||
                       ((r_phase == PH_MAGIC1) && !i_cls.is_six) ||
                       w_skip_bad ||
                       (w_term && !r_digit_seen) ||
                       ((r_phase == PH_NUM_M) && w_term && r_digit_seen && w_hdr_bad));
        w_header     = (r_phase == PH_NUM_M) && w_term && r_digit_seen && !w_hdr_bad;
        w_pix        = !w_eos && (r_phase == PH_PIXELS) && (r_ch == 2'd2);
        w_last       = (r_left <= PW'(1));
        w_dim        = r_neg ? '0 : r_acc;
        w_acc_next   = {4'b0, r_acc} * (AW+4)'(10) + (AW+4)'(i_cls.data[3:0]);
        w_prod       = {{AW{1'b0}}, r_width} * {{AW{1'b0}}, r_height};
        unique case (r_phase)
            PH_SKIP_W, PH_MAGIC0, PH_MAGIC1: begin
                w_skip_stay = PH_SKIP_W;
                w_skip_next = PH_NUM_W;
            end
            PH_NUM_W, PH_SKIP_H: begin
                w_skip_stay = PH_SKIP_H;
                w_skip_next = PH_NUM_H;
            end
            default: begin
                w_skip_stay = PH_SKIP_M;
                w_skip_next = PH_NUM_M;
            end
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        if (w_go) begin
            priority if (w_eos) begin
                n_phase = PH_MAGIC0;
            end else if (w_fail) begin
                n_phase = PH_DONE;
            end else if (w_skip_mode) begin
                n_phase = w_skip_take ? w_skip_next : w_skip_stay;
            end else begin
                unique case (r_phase)
                    PH_MAGIC0: n_phase = PH_MAGIC1;
                    PH_MAGIC1: n_phase = PH_SKIP_W;
                    PH_NUM_M:  n_phase = w_header ? PH_PIXELS : r_phase;
                    PH_PIXELS: n_phase = (w_pix && w_last) ? PH_DONE : r_phase;
                    default:   n_phase = r_phase;
                endcase
            end
        end
    end

    always_comb begin
        n_acc        = r_acc;
        n_neg        = r_neg;
        n_digit_seen = r_digit_seen;
        n_in_comment = r_in_comment;
        n_width      = r_width;
        n_height     = r_height;
        n_ch         = r_ch;
        n_red        = r_red;
        n_green      = r_green;
        n_left       = r_left;
        o_res_push   = 1'b0;
        o_res        = '{kind: KIND_ERROR, pixel: '0, width: '0, height: '0,
                         last_pixel: 1'b0};
        if (w_eos) begin
            n_acc        = '0;
            n_neg        = 1'b0;
            n_digit_seen = 1'b0;
            n_in_comment = 1'b0;
            n_width      = '0;
            n_height     = '0;
            n_ch         = '0;
            n_red        = '0;
            n_green      = '0;
            n_left       = '0;
            o_res_push   = w_go && (r_phase != PH_DONE);
        end else if (w_fail) begin
            o_res_push = w_go;
        end else begin
            if (w_num && i_cls.is_digit) begin
                n_acc        = (w_acc_next > (AW+4)'(NUM_CAP)) ? AW'(NUM_CAP)
                                                                : w_acc_next[AW-1:0];
                n_digit_seen = 1'b1;
            end
            if (w_reparse) begin
                if (r_phase == PH_NUM_W) begin
                    n_width = w_dim;
                end else begin
                    n_height = w_dim;
                end
            end
            if (w_skip_mode) begin
                if (w_cmt) begin
                    n_in_comment = !i_cls.is_nl;
                end else begin
                    n_in_comment = i_cls.is_hash;
                end
                if (w_skip_take) begin
                    n_acc        = i_cls.is_digit ? AW'(i_cls.data[3:0]) : '0;
                    n_neg        = i_cls.is_minus;
                    n_digit_seen = i_cls.is_digit;
                end
            end
            if (w_header) begin
                n_left     = w_prod[PW-1:0];
                n_ch       = '0;
                o_res_push = w_go;
                o_res      = '{kind: KIND_HEADER, pixel: '0,
                               width: DIM_W'(r_width), height: DIM_W'(r_height),
                               last_pixel: 1'b0};
            end
            if (!w_eos && r_phase == PH_PIXELS) begin
                unique case (r_ch)
                    2'd0: begin
                        n_red = i_cls.data;
                        n_ch  = 2'd1;
                    end
                    2'd1: begin
                        n_green = i_cls.data;
                        n_ch    = 2'd2;
                    end
                    default: begin
                        n_ch       = '0;
                        n_left     = (r_left != '0) ? r_left - 1'b1 : r_left;
                        o_res_push = w_go;
                        o_res      = '{kind: KIND_PIXEL,
                                       pixel: {ALPHA, r_red, r_green, i_cls.data},
                                       width: '0, height: '0, last_pixel: w_last};
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_MAGIC0;
            r_acc        <= '0;
            r_neg        <= 1'b0;
            r_digit_seen <= 1'b0;
            r_in_comment <= 1'b0;
            r_width      <= '0;
            r_height     <= '0;
            r_ch         <= '0;
            r_red        <= '0;
            r_green      <= '0;
            r_left       <= '0;
        end else begin
            r_phase <= n_phase;
            if (w_go) begin
                r_acc        <= n_acc;
                r_neg        <= n_neg;
                r_digit_seen <= n_digit_seen;
                r_in_comment <= n_in_comment;
                r_width      <= n_width;
                r_height     <= n_height;
                r_ch         <= n_ch;
                r_red        <= n_red;
                r_green      <= n_green;
                r_left       <= n_left;
            end
        end
    end

endmodule

// ----- src/ppm_p6_stream_decoder_unit.sv -----
// Top level of the PPM P6 stream decoder.
// Depends on ppm_pkg, ppm_front, ppm_fifo and ppm_back.
//
// Usage:
//   Input queue: drive i_data_byte / i_end_of_stream and raise push; a byte
//   is taken on an edge where push is high and full is low.
//   Result queue: while empty is low the oldest result sits on o_kind,
//   o_pixel, o_width, o_height, o_last_pixel; raise pop to take it.
//   A file is the magic, a header of width, height and maxval, one
//   separator, then R,G,B bytes. One header result, one pixel result per
//   three data bytes (0xFFRRGGBB, last one flagged), or one error result.
//   An end-of-stream item rearms the parser and reports an error if the
//   image was not complete.
// Timing:
//   One byte per cycle sustained while pop keeps up. A byte is first
//   written into the item queue; the parser then carries it from there
//   into the two-entry result queue, where its result becomes visible.
//   If pop stays low the result queue fills, the parser stops, the item
//   queue fills and full rises; nothing is lost.
// Reset: synchronous, active low; both queues empty, parser expects 'P'.
module ppm_p6_stream_decoder_unit
    import ppm_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       i_data_byte,
    input  logic             i_end_of_stream,
    output logic             empty,
    input  logic             pop,
    output logic [1:0]       o_kind,
    output logic [PIX_W-1:0] o_pixel,
    output logic [DIM_W-1:0] o_width,
    output logic [DIM_W-1:0] o_height,
    output logic             o_last_pixel
);
    t_cls w_cls_in, w_cls_q;
    t_res w_res_in, w_res_q;
    logic w_item_empty, w_take, w_res_full, w_res_push;

    ppm_front u_front (
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_cls           (w_cls_in)
    );

    ppm_fifo #(
        .WIDTH ($bits(t_cls)),
        .DEPTH (2)
    ) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_cls_in),
        .o_full  (full),
        .i_pop   (w_take),
        .o_data  (w_cls_q),
        .o_empty (w_item_empty)
    );

    ppm_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!w_item_empty),
        .i_cls      (w_cls_q),
        .o_take     (w_take),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_res      (w_res_in)
    );

    ppm_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_q),
        .o_empty (empty)
    );

    assign o_kind       = w_res_q.kind;
    assign o_pixel      = w_res_q.pixel;
    assign o_width      = w_res_q.width;
    assign o_height     = w_res_q.height;
    assign o_last_pixel = w_res_q.last_pixel;

endmodule

// ----- src/ppm_p6_stream_decoder_unit_chk.sv -----
// Port-level checker for the PPM P6 stream decoder, bound to the top level.
// Depends on ppm_pkg and ppm_p6_stream_decoder_unit_assert.svh.
`include "ppm_p6_stream_decoder_unit_assert.svh"

module ppm_p6_stream_decoder_unit_chk
    import ppm_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             empty,
    input logic             pop,
    input logic [1:0]       o_kind,
    input logic [PIX_W-1:0] o_pixel,
    input logic [DIM_W-1:0] o_width,
    input logic [DIM_W-1:0] o_height,
    input logic             o_last_pixel
);
    localparam bit DIM_FITS = (MAX_DIM < (1 << DIM_W));

    `PPM_ASSERT_NEXT(a_reset_empties, i_clk, !i_rst_n, empty, "queue not empty after reset")
    `PPM_ASSERT_IMPLY(a_plain_zero, i_clk, i_rst_n, !empty && o_kind != KIND_PIXEL, o_pixel == '0 && !o_last_pixel, "non-pixel result carries pixel data")
    `PPM_ASSERT_IMPLY(a_alpha, i_clk, i_rst_n, !empty && o_kind == KIND_PIXEL, o_pixel[PIX_W-1:PIX_W-8] == ALPHA, "pixel without opaque alpha")
    `PPM_ASSERT_IMPLY(a_header_dims, i_clk, i_rst_n, DIM_FITS && !empty && o_kind == KIND_HEADER, o_width != '0 && o_height != '0, "header with zero dimension")
    `PPM_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n && !empty && !pop, !i_rst_n || (!empty && $stable(o_kind) && $stable(o_pixel)), "stalled result changed")

endmodule

bind ppm_p6_stream_decoder_unit ppm_p6_stream_decoder_unit_chk #(
    .MAX_DIM (MAX_DIM)
) u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .empty        (empty),
    .pop          (pop),
    .o_kind       (o_kind),
    .o_pixel      (o_pixel),
    .o_width      (o_width),
    .o_height     (o_height),
    .o_last_pixel (o_last_pixel)
);
